[sv/efs_pkg.sv]
// ----------------------------------------------------------------------------
// efs_pkg
// Shared types and constants of the fixed-length EDF job scheduler.
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int IDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int STAMP_W    = 16;
  localparam int TIME_W     = 17;
  localparam int DUR_W      = 8;
  localparam int JOB_IDX_W  = 4;
  localparam logic [DUR_W-1:0] DUR_RESET = 8'd6;

  // one stored job as it travels around the ring
  typedef struct packed {
    logic [STAMP_W-1:0] rel;
    logic [STAMP_W-1:0] dl;
    logic               done;
  } job_t;

  // job picked by the search unit
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  start;
    logic [STAMP_W-1:0] dl;
  } sel_t;

endpackage

[sv/edf_fixed_length_job_scheduler_top.sv]
// ----------------------------------------------------------------------------
// edf_fixed_length_job_scheduler_top
// Non-preemptive earliest-deadline-first scheduler for equal-length jobs.
// ----------------------------------------------------------------------------
// Usage:
//   Jobs are loaded one per transaction on start/busy (release, deadline,
//   last_job); busy stays low during a load. The job with last_job set
//   loads and then starts scheduling; busy stays high until the last result
//   has been produced. Loads beyond MAX_JOBS jobs are dropped. For each
//   placed job the job ring makes one full rotation past the search unit,
//   then the job is placed. The result appears on result_valid_o for one
//   cycle right after that. last_result_o marks the final result; crisis_o
//   marks a missed deadline, which also ends the schedule. The receiver
//   cannot stall results. task_duration is written over the cfg channel
//   (always ready); the user must write it only while idle; the block
//   itself does not enforce this. Reset empties the job set, sets
//   task_duration to 6 and drops busy.
// ----------------------------------------------------------------------------
module edf_fixed_length_job_scheduler_top
  import efs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [STAMP_W-1:0]   release_time_i,
  input  logic [STAMP_W-1:0]   deadline_time_i,
  input  logic                 last_job_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [DUR_W-1:0]     cfg_data_i,
  output logic                 result_valid_o,
  output logic [JOB_IDX_W-1:0] job_index_o,
  output logic [TIME_W-1:0]    start_time_o,
  output logic                 crisis_o,
  output logic                 last_result_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int WIDE_W = (IDX_W > JOB_IDX_W) ? IDX_W : JOB_IDX_W;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_JOBS - 1);

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d, emitted_q, emitted_d;
  logic [TIME_W-1:0] cur_q, cur_d;
  logic [DUR_W-1:0]  dur_q;

  logic                 res_valid_q;
  logic [JOB_IDX_W-1:0] res_idx_q;
  logic [TIME_W-1:0]    res_start_q;
  logic                 res_crisis_q, res_last_q;

  job_t              ring [MAX_JOBS];
  sel_t              sel;
  logic              accept, do_load, shift, mark, clear, cand;
  logic [TIME_W:0]   finish;
  logic              crisis, is_last;
  logic [WIDE_W-1:0] idx_wide;
  logic [CNT_W-1:0]  emitted_inc;

  assign accept  = start && !busy;
  assign do_load = accept && (loaded_q < CNT_W'(MAX_JOBS));
  assign shift   = (state_q == ST_SCAN);
  assign cand    = ({1'b0, pos_q} < loaded_q) && !ring[0].done;

  assign finish      = {1'b0, sel.start} + (TIME_W + 1)'(dur_q);
  assign crisis      = finish > (TIME_W + 1)'(sel.dl);
  assign emitted_inc = emitted_q + CNT_W'(1);
  assign is_last     = crisis || (emitted_inc == loaded_q);
  assign mark        = (state_q == ST_EMIT) && !is_last;
  assign clear       = (state_q == ST_EMIT) && is_last;
  assign idx_wide    = WIDE_W'(sel.idx);

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    efs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .next_i     (ring[(i + 1) % MAX_JOBS]),
      .load_i     (do_load && (loaded_q[IDX_W-1:0] == IDX_W'(i))),
      .load_rel_i (release_time_i),
      .load_dl_i  (deadline_time_i),
      .mark_i     (mark && (sel.idx == IDX_W'(i))),
      .clear_i    (clear),
      .job_o      (ring[i])
    );
  end

  efs_head u_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (shift),
    .first_i    (pos_q == '0),
    .idx_i      (pos_q),
    .cand_i     (cand),
    .job_i      (ring[0]),
    .cur_time_i (cur_q),
    .sel_o      (sel)
  );

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    loaded_d  = loaded_q;
    emitted_d = emitted_q;
    cur_d     = cur_q;
    case (state_q)
      ST_IDLE: begin
        if (do_load) begin
          loaded_d = loaded_q + CNT_W'(1);
        end
        if (accept && last_job_i) begin
          state_d = ST_SCAN;
          pos_d   = '0;
        end
      end
      ST_SCAN: begin
        pos_d = pos_q + IDX_W'(1);
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (is_last) begin
          state_d   = ST_IDLE;
          loaded_d  = '0;
          emitted_d = '0;
          cur_d     = '0;
        end else begin
          state_d   = ST_SCAN;
          emitted_d = emitted_inc;
          cur_d     = finish[TIME_W-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      loaded_q    <= '0;
      emitted_q   <= '0;
      cur_q       <= '0;
      dur_q       <= DUR_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      loaded_q    <= loaded_d;
      emitted_q   <= emitted_d;
      cur_q       <= cur_d;
      res_valid_q <= (state_q == ST_EMIT);
      if (cfg_valid_i && cfg_ready_o) begin
        dur_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      res_idx_q    <= idx_wide[JOB_IDX_W-1:0];
      res_start_q  <= sel.start;
      res_crisis_q <= crisis;
      res_last_q   <= is_last;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign job_index_o    = res_idx_q;
  assign start_time_o   = res_start_q;
  assign crisis_o       = res_crisis_q;
  assign last_result_o  = res_last_q;

  // a result only ever follows a placement cycle
  a_result_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without placement");

  // a missed deadline always ends the schedule
  a_crisis_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && crisis_o) |-> (last_result_o && !busy))
    else $error("crisis result did not end the schedule");

  // while scheduling, some stored job is still unplaced
  a_pending_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (emitted_q < loaded_q))
    else $error("scheduling with no pending job");

  // the ring is back at its home position whenever it is not rotating
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (pos_q == '0))
    else $error("ring left off its home position");

endmodule

[sv/efs_cell.sv]
// ----------------------------------------------------------------------------
// efs_cell
// One slot of the job ring: holds a job and passes it to its neighbor.
// ----------------------------------------------------------------------------
module efs_cell
  import efs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  job_t               next_i,
  input  logic               load_i,
  input  logic [STAMP_W-1:0] load_rel_i,
  input  logic [STAMP_W-1:0] load_dl_i,
  input  logic               mark_i,
  input  logic               clear_i,
  output job_t               job_o
);

  logic [STAMP_W-1:0] rel_q;
  logic [STAMP_W-1:0] dl_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (clear_i || load_i) begin
      done_q <= 1'b0;
    end else if (mark_i) begin
      done_q <= 1'b1;
    end else if (shift_i) begin
      done_q <= next_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rel_q <= load_rel_i;
      dl_q  <= load_dl_i;
    end else if (shift_i) begin
      rel_q <= next_i.rel;
      dl_q  <= next_i.dl;
    end
  end

  assign job_o = '{rel: rel_q, dl: dl_q, done: done_q};

endmodule

[sv/efs_head.sv]
// ----------------------------------------------------------------------------
// efs_head
// Search unit at the ring head: tracks the best released job and the best
// job among the earliest releases while the ring rotates past it.
// ----------------------------------------------------------------------------
module efs_head
  import efs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              first_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic              cand_i,
  input  job_t              job_i,
  input  logic [TIME_W-1:0] cur_time_i,
  output sel_t              sel_o
);

  logic               rel_found_q, e_found_q;
  logic [IDX_W-1:0]   rel_idx_q, e_idx_q;
  logic [STAMP_W-1:0] rel_dl_q, e_dl_q, e_rel_q;
  logic               prev_rel, prev_e, take_rel, take_e;

  always_comb begin
    prev_rel = rel_found_q && !first_i;
    prev_e   = e_found_q && !first_i;
    take_rel = cand_i && ({1'b0, job_i.rel} <= cur_time_i) &&
               (!prev_rel || (job_i.dl < rel_dl_q));
    // earliest release first, then deadline; strict compares keep lower index
    take_e   = cand_i && (!prev_e || (job_i.rel < e_rel_q) ||
               ((job_i.rel == e_rel_q) && (job_i.dl < e_dl_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_found_q <= 1'b0;
      e_found_q   <= 1'b0;
    end else if (step_i) begin
      rel_found_q <= prev_rel || take_rel;
      e_found_q   <= prev_e || take_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && take_rel) begin
      rel_idx_q <= idx_i;
      rel_dl_q  <= job_i.dl;
    end
    if (step_i && take_e) begin
      e_idx_q <= idx_i;
      e_rel_q <= job_i.rel;
      e_dl_q  <= job_i.dl;
    end
  end

  // best released job starts at the current time; nothing released yet: time jumps to the earliest pending release
  always_comb begin
    if (rel_found_q) begin
      sel_o = '{idx: rel_idx_q, start: cur_time_i, dl: rel_dl_q};
    end else begin
      sel_o = '{idx: e_idx_q, start: {1'b0, e_rel_q}, dl: e_dl_q};
    end
  end

endmodule
